>>> rtl/servo_attitude_compensator_macros.svh
// Assertion macros shared by the servo attitude compensator RTL.
// Needs a clock named i_clk and a reset named i_rst_n in the including scope.
`ifndef SERVO_ATTITUDE_COMPENSATOR_MACROS_SVH
`define SERVO_ATTITUDE_COMPENSATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define SAC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define SAC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SAC_ASSERT_NOW(lbl, ante, cons)
`define SAC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/sac_pkg.sv
// Package of the servo attitude compensator: state type, control struct
// and fixed constants. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sac_pkg;

    // Field and datapath widths.
    localparam int ANGLE_W  = 16;
    localparam int TIME_W   = 32;
    localparam int CH_W     = 2;
    localparam int DUTY_W   = 12;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 34;
    localparam int SCALE_W  = ACC_W + 4;
    localparam int FRAC_W   = 18;
    localparam int COEF_W   = 64;
    localparam int IDX_W    = 3;
    localparam int TERMS    = 4;

    // Register map.
    localparam int NREG_CH      = 4;
    localparam int REG_ENABLE   = 4;
    localparam int REG_INTERVAL = 5;
    localparam int INTERVAL_RST = 20;

    // Pulse width limits and deadband in microseconds.
    localparam int DUTY_MIN = 500;
    localparam int DUTY_MAX = 2500;
    localparam int DEADBAND = 5;
    localparam int BASE_ONE = 4096;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CHAN,
        ST_MAC,
        ST_SCALE,
        ST_CLAMP,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    // Controls of the shared multiply-accumulate unit.
    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_clr;
    } t_mac_ctl;

endpackage

`default_nettype wire

>>> rtl/sac_mac.sv
// Shared signed 16x16 multiplier with a registered product and accumulator.
// Depends on sac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sac_mac (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire sac_pkg::t_mac_ctl                 i_ctl,
    input  wire logic signed [sac_pkg::ANGLE_W-1:0] i_a,
    input  wire logic signed [sac_pkg::ANGLE_W-1:0] i_b,
    output logic signed [sac_pkg::ACC_W-1:0]       o_acc
);

    logic signed [sac_pkg::PROD_W-1:0] r_prod;
    logic signed [sac_pkg::ACC_W-1:0]  r_acc;
    logic signed [sac_pkg::ACC_W-1:0]  n_acc;
    logic signed [sac_pkg::ACC_W-1:0]  prod_ext;

    // The product is sign extended and added on the cycle after it is formed.
    assign prod_ext = {{(sac_pkg::ACC_W - sac_pkg::PROD_W){r_prod[sac_pkg::PROD_W-1]}}, r_prod};

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.acc_en) begin
            n_acc = (i_ctl.acc_clr ? '0 : r_acc) + prod_ext;
        end
    end

    // Product and sum carry payload only, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (i_rst_n && i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

>>> rtl/servo_attitude_compensator.sv
// Servo attitude compensator: top level with sequencer, register file and
// output register. Depends on sac_pkg, sac_mac and the assertion macros.
//
// Use of the block:
// The attitude channel (s_axis) takes one word of roll, pitch, yaw and a
// millisecond time. The result channel (m_axis) gives one word per servo
// channel whose pulse width changes: channel number and duty in microseconds,
// with tlast on the final word of the sample. A sample that comes too soon
// after the last accepted one, or that changes no channel, gives no word.
// The configuration channel writes coefficients, the enable mask and the
// interval; it is always ready and should be used while the block is idle.
// Sequence: the accepting cycle and an interval check, then for each enabled
// channel CHAN, MAC (one coefficient term a cycle on the shared multiplier),
// SCALE, CLAMP and DECIDE, and CHAN alone for a disabled one, then EMIT, which
// visits the channels in turn to hand out results. tready is low from the
// check until the block is back in idle. EMIT waits on a channel whose word
// finds the output register still full while the receiver is not ready.
// Reset clears the coefficients, the mask, the stored time and the stored
// pulse widths, and sets the interval to 20 ms. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "servo_attitude_compensator_macros.svh"

module servo_attitude_compensator #(
    parameter int CHANNELS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Attitude words.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata from bit 0: roll_deg[15:0], pitch_deg[15:0], yaw_deg[15:0], time_ms[31:0]
    input  wire logic [79:0] i_s_axis_tdata,
    // Result words.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata from bit 0: channel[1:0], duty_us[11:0], two zero bits
    output logic [15:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    // Configuration writes.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [sac_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [sac_pkg::COEF_W-1:0] i_cfg_data
);

    // Channels that have registers; the rest never emit.
    localparam int NCH       = (CHANNELS < sac_pkg::NREG_CH) ? CHANNELS : sac_pkg::NREG_CH;
    localparam int CH_IDX_W  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int TERM_W    = 3;

    localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NCH - 1);

    // Configuration registers.
    logic [sac_pkg::COEF_W-1:0]   r_coef [NCH];
    logic [sac_pkg::NREG_CH-1:0]  r_mask;
    logic [15:0]                  r_interval;

    // Sample and state registers.
    logic signed [sac_pkg::ANGLE_W-1:0] r_roll;
    logic signed [sac_pkg::ANGLE_W-1:0] r_pitch;
    logic signed [sac_pkg::ANGLE_W-1:0] r_yaw;
    logic [sac_pkg::TIME_W-1:0]         r_time;
    logic [sac_pkg::TIME_W-1:0]         r_last_time;
    logic [sac_pkg::DUTY_W-1:0]         r_last_duty [NCH];
    logic [NCH-1:0]                     r_flag;

    // Sequencer registers.
    sac_pkg::t_state      r_state;
    sac_pkg::t_state      n_state;
    logic [CH_IDX_W-1:0]  r_ch;
    logic [CH_IDX_W-1:0]  n_ch;
    logic [TERM_W-1:0]    r_term;
    logic [TERM_W-1:0]    n_term;

    // Datapath registers.
    logic signed [sac_pkg::SCALE_W-1:0] r_scaled;
    logic [sac_pkg::DUTY_W-1:0]         r_duty;

    // Output register.
    logic                         r_out_valid;
    logic [sac_pkg::CH_W-1:0]     r_out_ch;
    logic [sac_pkg::DUTY_W-1:0]   r_out_duty;
    logic                         r_out_last;

    // Combinational signals.
    logic                               in_fire;
    logic                               cfg_fire;
    logic                               too_soon;
    logic                               ch_enabled;
    logic                               ch_is_last;
    logic                               out_free;
    logic                               out_load;
    logic                               flags_above;
    logic                               skip;
    logic                               keep;
    logic [sac_pkg::TIME_W-1:0]         elapsed;
    logic signed [sac_pkg::ACC_W-1:0]   acc;
    logic signed [sac_pkg::SCALE_W-1:0] acc_ext;
    logic signed [sac_pkg::SCALE_W-sac_pkg::FRAC_W-1:0] whole;
    logic [sac_pkg::DUTY_W-1:0]         n_duty;
    logic signed [sac_pkg::DUTY_W:0]    diff;
    logic [sac_pkg::DUTY_W-1:0]         cur_last;
    logic [sac_pkg::COEF_W-1:0]         cur_coef;
    sac_pkg::t_mac_ctl                  mac_ctl;
    logic signed [sac_pkg::ANGLE_W-1:0] mac_a;
    logic signed [sac_pkg::ANGLE_W-1:0] mac_b;

    assign in_fire    = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_fire   = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;
    assign o_s_axis_tready = (r_state == sac_pkg::ST_IDLE);

    // Interval check, modulo 2^32.
    assign elapsed  = r_time - r_last_time;
    assign too_soon = elapsed < {16'd0, r_interval};

    assign ch_enabled = r_mask[sac_pkg::CH_W'(r_ch)];
    assign ch_is_last = (r_ch == LAST_CH);
    assign cur_coef   = r_coef[r_ch];
    assign cur_last   = r_last_duty[r_ch];
    assign out_free   = !r_out_valid || i_m_axis_tready;

    // Operands of the shared unit: base against 4096, then each gain against its angle.
    always_comb begin
        mac_a = signed'(cur_coef[r_term[1:0]*sac_pkg::ANGLE_W +: sac_pkg::ANGLE_W]);
        case (r_term)
            3'd1:    mac_b = r_roll;
            3'd2:    mac_b = r_pitch;
            3'd3:    mac_b = r_yaw;
            default: mac_b = sac_pkg::ANGLE_W'(sac_pkg::BASE_ONE);
        endcase
    end

    // Multiply while the term is below four, add the previous product after the first.
    always_comb begin
        mac_ctl.mul_en  = (r_state == sac_pkg::ST_MAC) && (r_term < TERM_W'(sac_pkg::TERMS));
        mac_ctl.acc_en  = (r_state == sac_pkg::ST_MAC) && (r_term != '0);
        mac_ctl.acc_clr = (r_term == TERM_W'(1));
    end

    sac_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (acc)
    );

    // Ten times the sum, then the whole part after flooring, then the clamp.
    assign acc_ext = {{(sac_pkg::SCALE_W - sac_pkg::ACC_W){acc[sac_pkg::ACC_W-1]}}, acc};
    assign whole   = r_scaled[sac_pkg::SCALE_W-1:sac_pkg::FRAC_W];

    always_comb begin
        if (whole < 0) begin
            n_duty = sac_pkg::DUTY_W'(sac_pkg::DUTY_MIN);
        end else if (whole > (sac_pkg::SCALE_W - sac_pkg::FRAC_W)'(sac_pkg::DUTY_MAX
                              - sac_pkg::DUTY_MIN)) begin
            n_duty = sac_pkg::DUTY_W'(sac_pkg::DUTY_MAX);
        end else begin
            n_duty = sac_pkg::DUTY_W'(sac_pkg::DUTY_MIN) + whole[sac_pkg::DUTY_W-1:0];
        end
    end

    // Deadband test against the stored pulse width.
    assign diff = signed'({1'b0, r_duty}) - signed'({1'b0, cur_last});
    assign skip = (diff > -(sac_pkg::DUTY_W+1)'(sac_pkg::DEADBAND))
               && (diff < (sac_pkg::DUTY_W+1)'(sac_pkg::DEADBAND));
    assign keep = (r_state == sac_pkg::ST_DECIDE) && !skip;

    // Any pending result above the current channel.
    always_comb begin
        flags_above = 1'b0;
        for (int i = 0; i < NCH; i++) begin
            if (CH_IDX_W'(i) > r_ch) begin
                flags_above = flags_above | r_flag[i];
            end
        end
    end

    assign out_load = (r_state == sac_pkg::ST_EMIT) && r_flag[r_ch] && out_free;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sac_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = sac_pkg::ST_CHECK;
                end
            end
            sac_pkg::ST_CHECK: begin
                n_state = too_soon ? sac_pkg::ST_IDLE : sac_pkg::ST_CHAN;
            end
            sac_pkg::ST_CHAN: begin
                if (ch_enabled) begin
                    n_state = sac_pkg::ST_MAC;
                end else if (ch_is_last) begin
                    n_state = sac_pkg::ST_EMIT;
                end
            end
            sac_pkg::ST_MAC: begin
                if (r_term == TERM_W'(sac_pkg::TERMS)) begin
                    n_state = sac_pkg::ST_SCALE;
                end
            end
            sac_pkg::ST_SCALE: n_state = sac_pkg::ST_CLAMP;
            sac_pkg::ST_CLAMP: n_state = sac_pkg::ST_DECIDE;
            sac_pkg::ST_DECIDE: begin
                n_state = ch_is_last ? sac_pkg::ST_EMIT : sac_pkg::ST_CHAN;
            end
            sac_pkg::ST_EMIT: begin
                if (ch_is_last && (!r_flag[r_ch] || out_free)) begin
                    n_state = sac_pkg::ST_IDLE;
                end
            end
            default: n_state = sac_pkg::ST_IDLE;
        endcase
    end

    // Channel and term counters.
    always_comb begin
        n_ch   = r_ch;
        n_term = r_term;
        case (r_state)
            sac_pkg::ST_CHECK: n_ch = '0;
            sac_pkg::ST_CHAN: begin
                n_term = '0;
                if (!ch_enabled) begin
                    n_ch = ch_is_last ? '0 : r_ch + CH_IDX_W'(1);
                end
            end
            sac_pkg::ST_MAC: n_term = r_term + TERM_W'(1);
            sac_pkg::ST_DECIDE: n_ch = ch_is_last ? '0 : r_ch + CH_IDX_W'(1);
            sac_pkg::ST_EMIT: begin
                if (!r_flag[r_ch] || out_free) begin
                    n_ch = ch_is_last ? '0 : r_ch + CH_IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sac_pkg::ST_IDLE;
            r_ch        <= '0;
            r_term      <= '0;
            r_flag      <= '0;
            r_out_valid <= 1'b0;
            r_last_time <= '0;
            r_mask      <= '0;
            r_interval  <= 16'(sac_pkg::INTERVAL_RST);
            for (int i = 0; i < NCH; i++) begin
                r_coef[i]      <= '0;
                r_last_duty[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_term  <= n_term;
            // Configuration writes; out-of-range indexes are dropped.
            if (cfg_fire) begin
                for (int i = 0; i < NCH; i++) begin
                    if (i_cfg_index == sac_pkg::IDX_W'(i)) begin
                        r_coef[i] <= i_cfg_data;
                    end
                end
                if (i_cfg_index == sac_pkg::IDX_W'(sac_pkg::REG_ENABLE)) begin
                    r_mask <= i_cfg_data[sac_pkg::NREG_CH-1:0];
                end
                if (i_cfg_index == sac_pkg::IDX_W'(sac_pkg::REG_INTERVAL)) begin
                    r_interval <= i_cfg_data[15:0];
                end
            end
            // Stored time moves only on an accepted sample.
            if ((r_state == sac_pkg::ST_CHECK) && !too_soon) begin
                r_last_time <= r_time;
            end
            // A changed channel stores its width and marks a pending result.
            if (keep) begin
                r_last_duty[r_ch] <= r_duty;
                r_flag[r_ch]      <= 1'b1;
            end
            if (out_load) begin
                r_flag[r_ch] <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_roll  <= signed'(i_s_axis_tdata[15:0]);
            r_pitch <= signed'(i_s_axis_tdata[31:16]);
            r_yaw   <= signed'(i_s_axis_tdata[47:32]);
            r_time  <= i_s_axis_tdata[79:48];
        end
        if (r_state == sac_pkg::ST_SCALE) begin
            r_scaled <= (acc_ext <<< 3) + (acc_ext <<< 1);
        end
        if (r_state == sac_pkg::ST_CLAMP) begin
            r_duty <= n_duty;
        end
        if (out_load) begin
            r_out_ch   <= sac_pkg::CH_W'(r_ch);
            r_out_duty <= r_last_duty[r_ch];
            r_out_last <= !flags_above;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_duty, r_out_ch};
    assign o_m_axis_tlast  = r_out_last;

    // No pending results survive the return to idle.
    `SAC_ASSERT_NOW(a_flags_idle, r_state == sac_pkg::ST_IDLE, r_flag == '0)
    // The term counter never runs past the last accumulate.
    `SAC_ASSERT_NOW(a_term_range, r_state == sac_pkg::ST_MAC, r_term <= TERM_W'(sac_pkg::TERMS))
    // An accepted sample leaves its time as the stored time.
    `SAC_ASSERT_NEXT(a_time_store, (r_state == sac_pkg::ST_CHECK) && !too_soon,
                     r_last_time == $past(r_time))
    // Loading a word always shows it on the result channel.
    `SAC_ASSERT_NEXT(a_out_load, out_load, r_out_valid)
    // A word is loaded only into a free output register.
    `SAC_ASSERT_NOW(a_out_free, out_load, !r_out_valid || i_m_axis_tready)

endmodule

`default_nettype wire

>>> tb/sv/sac_tb_pkg.sv
// Scoreboard for the servo attitude compensator testbench: predicts the duty
// updates of every accepted attitude word and checks the result words.
// Depends on sac_pkg for the duty limits, the deadband and the register map.
`timescale 1ns / 1ps

package sac_tb_pkg;

    // One expected or observed result word.
    typedef struct packed {
        logic [1:0]  channel;
        logic [11:0] duty_us;
        logic        last;
    } duty_update_t;

    class servo_duty_tracker;
        logic [63:0]  coef [sac_pkg::NREG_CH];
        logic [3:0]   enable;
        logic [15:0]  interval;
        logic [31:0]  last_time;
        logic [11:0]  last_duty [sac_pkg::NREG_CH];
        duty_update_t pending_updates [$];
        int unsigned  failures;

        function new();
            int c;
            for (c = 0; c < sac_pkg::NREG_CH; c++) begin
                coef[c] = '0;
                last_duty[c] = '0;
            end
            enable = '0;
            interval = 16'(sac_pkg::INTERVAL_RST);
            last_time = '0;
            failures = 0;
        endfunction

        // Mirror of one accepted configuration write; unknown indexes are dropped.
        function void write_reg(logic [2:0] idx, logic [63:0] data);
            if (idx < sac_pkg::NREG_CH)
                coef[idx] = data;
            else if (idx == sac_pkg::REG_ENABLE)
                enable = data[3:0];
            else if (idx == sac_pkg::REG_INTERVAL)
                interval = data[15:0];
        endfunction

        // Works out the duty updates that one accepted attitude word causes.
        function void note_sample(logic signed [15:0] roll, logic signed [15:0] pitch,
                                  logic signed [15:0] yaw, logic [31:0] now);
            logic [31:0]        gap;
            logic signed [15:0] k_base, k_roll, k_pitch, k_yaw;
            longint             acc, duty, diff;
            duty_update_t       upd [sac_pkg::NREG_CH];
            int                 n, c;
            gap = now - last_time;
            if (gap < {16'b0, interval})
                return;
            last_time = now;
            n = 0;
            for (c = 0; c < sac_pkg::NREG_CH; c++) begin
                if (!enable[c])
                    continue;
                k_base  = coef[c][15:0];
                k_roll  = coef[c][31:16];
                k_pitch = coef[c][47:32];
                k_yaw   = coef[c][63:48];
                // Exact sum in Q.18, then floor by an arithmetic shift.
                acc = longint'(k_base) * sac_pkg::BASE_ONE
                    + longint'(k_roll) * longint'(roll)
                    + longint'(k_pitch) * longint'(pitch)
                    + longint'(k_yaw) * longint'(yaw);
                duty = (longint'(sac_pkg::DUTY_MIN) * (longint'(1) << sac_pkg::FRAC_W)
                        + 10 * acc) >>> sac_pkg::FRAC_W;
                if (duty < sac_pkg::DUTY_MIN)
                    duty = sac_pkg::DUTY_MIN;
                if (duty > sac_pkg::DUTY_MAX)
                    duty = sac_pkg::DUTY_MAX;
                // Small changes stay inside the deadband and are not sent.
                diff = duty - longint'(last_duty[c]);
                if (diff > -sac_pkg::DEADBAND && diff < sac_pkg::DEADBAND)
                    continue;
                last_duty[c] = duty[11:0];
                upd[n].channel = 2'(c);
                upd[n].duty_us = duty[11:0];
                upd[n].last = 1'b0;
                n++;
            end
            if (n > 0)
                upd[n - 1].last = 1'b1;
            for (c = 0; c < n; c++)
                pending_updates.push_back(upd[c]);
        endfunction

        // Compares one result word with the oldest expected update.
        function void check_update(logic [1:0] ch, logic [11:0] duty, logic last_flag);
            duty_update_t want;
            if (pending_updates.size() == 0) begin
                $error("unexpected word: channel %0d duty_us %0d last %0d",
                       ch, duty, last_flag);
                failures++;
                return;
            end
            want = pending_updates.pop_front();
            if (ch !== want.channel) begin
                $error("channel: expected %0d, actual %0d", want.channel, ch);
                failures++;
            end
            if (duty !== want.duty_us) begin
                $error("duty_us: expected %0d, actual %0d", want.duty_us, duty);
                failures++;
            end
            if (last_flag !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, last_flag);
                failures++;
            end
        endfunction

        function int pending();
            return pending_updates.size();
        endfunction
    endclass

endpackage

>>> tb/sv/tb_top.sv
// Top of the servo attitude compensator testbench: clock, reset, stimulus,
// result sink and timeout. Depends on sac_pkg, sac_tb_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import sac_tb_pkg::*;

    localparam int LIMIT         = 400000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 50;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_s_axis_tvalid = 1'b0;
    logic                        o_s_axis_tready;
    logic [79:0]                 i_s_axis_tdata = '0;
    logic                        o_m_axis_tvalid;
    logic                        i_m_axis_tready = 1'b0;
    logic [15:0]                 o_m_axis_tdata;
    logic                        o_m_axis_tlast;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [sac_pkg::IDX_W-1:0]   i_cfg_index = '0;
    logic [sac_pkg::COEF_W-1:0]  i_cfg_data = '0;

    servo_duty_tracker duty_model;

    int          tx_idle_pct = 8;
    int          rx_idle_pct = 63;
    logic        hold_go = 1'b0;
    int unsigned cycle_count = 0;

    // Stimulus state: last angles and time sent, interval now programmed.
    logic [15:0] cur_roll = '0, cur_pitch = '0, cur_yaw = '0;
    logic [31:0] cur_time = '0;
    logic [15:0] cur_interval = 16'(sac_pkg::INTERVAL_RST);

    servo_attitude_compensator #(.CHANNELS(4)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Every result word is checked against the predicted updates.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            duty_model.check_update(o_m_axis_tdata[1:0], o_m_axis_tdata[13:2],
                                    o_m_axis_tlast);
    end

    // Result sink: random back-pressure, plus one long hold-off on request.
    initial begin : result_sink
        logic hold_done;
        int   held;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                i_m_axis_tready <= 1'b0;
                hold_done = 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge i_clk);
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Sends one attitude word, idling first at the current rate.
    task automatic put_sample(input logic [15:0] roll, input logic [15:0] pitch,
                              input logic [15:0] yaw, input logic [31:0] now);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {now, yaw, pitch, roll};
        do @(posedge i_clk); while (!o_s_axis_tready);
        duty_model.note_sample(roll, pitch, yaw, now);
    endtask

    // Leaves cfg valid high; the caller lowers it after the last write.
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        duty_model.write_reg(idx, data);
    endtask

    // Waits until every expected word has come and the block is idle.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (duty_model.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random coefficients (mostly servo-like gains, some raw words), enable mask and interval.
    task automatic load_phase_config(input int phase);
        logic [63:0] word;
        int          c;
        for (c = 0; c < sac_pkg::NREG_CH; c++) begin
            if ($urandom_range(0, 3) == 0)
                word = {$urandom, $urandom};
            else
                word = {16'($urandom_range(0, 8192) - 4096),
                        16'($urandom_range(0, 8192) - 4096),
                        16'($urandom_range(0, 8192) - 4096),
                        16'($urandom_range(0, 12800))};
            cfg_write(3'(c), word);
        end
        word = {$urandom, $urandom};
        word[3:0] = (phase < 2) ? 4'hF : 4'($urandom_range(1, 15));
        cfg_write(3'(sac_pkg::REG_ENABLE), word);
        word = {$urandom, $urandom};
        case (phase)
            2:       word[15:0] = 16'h0000;
            4:       word[15:0] = 16'hFFFF;
            default: word[15:0] = 16'($urandom_range(1, 40));
        endcase
        cur_interval = word[15:0];
        cfg_write(3'(sac_pkg::REG_INTERVAL), word);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] step_angle(logic [15:0] prev, int mode);
        if (mode < 55)
            return prev + 16'($urandom_range(0, 40)) - 16'd20;
        if (mode < 85)
            return 16'($urandom_range(0, 11520)) - 16'd5760;
        return 16'($urandom);
    endfunction

    // Mostly small attitude steps at the update rate; some early, jumping or wrapped times.
    task automatic send_random_sample();
        int mode, r;
        mode = $urandom_range(0, 99);
        cur_roll = step_angle(cur_roll, mode);
        cur_pitch = step_angle(cur_pitch, mode);
        cur_yaw = step_angle(cur_yaw, mode);
        r = $urandom_range(0, 99);
        if (r < 75)
            cur_time = cur_time + cur_interval + $urandom_range(0, 5);
        else if (r < 88)
            cur_time = cur_time + ((cur_interval == 0) ? 0 :
                                   $urandom_range(0, cur_interval - 1));
        else if (r < 95)
            cur_time = $urandom;
        else
            cur_time = cur_time - $urandom_range(1, 100);
        put_sample(cur_roll, cur_pitch, cur_yaw, cur_time);
    endtask

    initial begin : stimulus
        logic [63:0] word;
        int          idx, phase, n;
        duty_model = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: the first word is too soon after time zero, the next has no channel.
        put_sample(16'h0000, 16'h0000, 16'h0000, 32'd5);
        put_sample(16'h0000, 16'h0000, 16'h0000, 32'd20);
        settle();

        // Extreme gains on two channels, a plain servo law on one, zero gains on the last.
        cfg_write(3'd0, {4{16'h7FFF}});
        cfg_write(3'd1, {4{16'h8000}});
        cfg_write(3'd2, {16'h0400, 16'hF800, 16'h1000, 16'h1900});
        cfg_write(3'd3, 64'h0);
        word = {$urandom, $urandom};
        word[3:0] = 4'hF;
        cfg_write(3'(sac_pkg::REG_ENABLE), word);
        word = {$urandom, $urandom};
        word[15:0] = 16'd10;
        cfg_write(3'(sac_pkg::REG_INTERVAL), word);
        for (idx = sac_pkg::REG_INTERVAL + 1; idx < (1 << sac_pkg::IDX_W); idx++)
            cfg_write(3'(idx), {$urandom, $urandom});
        i_cfg_valid <= 1'b0;

        put_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd40);
        put_sample(16'h8000, 16'h8000, 16'h8000, 32'd50);
        put_sample(16'h0000, 16'h0000, 16'h0000, 32'd60);
        // Same attitude again: every channel stays in the deadband.
        put_sample(16'h0000, 16'h0000, 16'h0000, 32'd70);
        put_sample(16'h0001, 16'h0000, 16'h0000, 32'd80);
        put_sample(16'd40, 16'h0000, 16'h0000, 32'd90);
        put_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd95);
        // Time wraps around the top of the counter.
        put_sample(16'hC000, 16'h4000, 16'h2000, 32'hFFFF_FFF0);
        put_sample(16'h4000, 16'hC000, 16'hE000, 32'd5);
        put_sample(16'h1234, 16'h5678, 16'h9ABC, 32'd10);
        settle();

        // Zero interval: a repeated time is still taken.
        word = {$urandom, $urandom};
        word[15:0] = 16'd0;
        cfg_write(3'(sac_pkg::REG_INTERVAL), word);
        word = {$urandom, $urandom};
        word[3:0] = 4'b0101;
        cfg_write(3'(sac_pkg::REG_ENABLE), word);
        i_cfg_valid <= 1'b0;
        put_sample(16'h0100, 16'hFF00, 16'h0080, 32'd10);
        put_sample(16'hFF00, 16'h0100, 16'hFF80, 32'd10);
        settle();

        // Largest interval, one millisecond short and then just met.
        word = {$urandom, $urandom};
        word[15:0] = 16'hFFFF;
        cfg_write(3'(sac_pkg::REG_INTERVAL), word);
        word = {$urandom, $urandom};
        word[3:0] = 4'b1010;
        cfg_write(3'(sac_pkg::REG_ENABLE), word);
        i_cfg_valid <= 1'b0;
        put_sample(16'h2000, 16'h2000, 16'h2000, 32'd10 + 32'hFFFE);
        put_sample(16'h2000, 16'h2000, 16'h2000, 32'd10 + 32'hFFFF);
        settle();

        // All channels off: the word is taken but gives nothing.
        word = {$urandom, $urandom};
        word[3:0] = 4'b0000;
        cfg_write(3'(sac_pkg::REG_ENABLE), word);
        i_cfg_valid <= 1'b0;
        put_sample(16'h0300, 16'h0300, 16'h0300, 32'd10 + 32'h1_FFFE);
        cur_time = 32'd10 + 32'h1_FFFE;

        // Random phases; the idle pattern changes every third phase.
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase / 3)
                0: begin
                    tx_idle_pct <= 8;
                    rx_idle_pct <= 63;
                end
                1: begin
                    tx_idle_pct <= 63;
                    rx_idle_pct <= 8;
                end
                default: begin
                    tx_idle_pct <= 0;
                    rx_idle_pct <= 0;
                end
            endcase
            load_phase_config(phase);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == 20)
                    hold_go <= 1'b1;
                send_random_sample();
            end
        end

        settle();
        if (duty_model.failures == 0 && duty_model.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
